[rtl/transaction_tag_tracker_assert.svh]
// Assertion macros for the tag tracker
`ifndef TRANSACTION_TAG_TRACKER_ASSERT_SVH
`define TRANSACTION_TAG_TRACKER_ASSERT_SVH
// a holds at every edge outside reset
`define TTT_ASSERT_ALWAYS(label, a) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a)) else $error("%m");
// a implies b at the same edge
`define TTT_ASSERT_IMPL(label, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error("%m");
// a implies b at the next edge
`define TTT_ASSERT_NEXT(label, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error("%m");
`endif

[rtl/ttt_pkg.sv]
// ----------------------------------------------------------------------------
// ttt_pkg
// Shared types and codes of the transaction tag tracker.
// ----------------------------------------------------------------------------
`default_nettype none
package ttt_pkg;
    localparam logic [1:0] CMD_ALLOC = 2'd0;
    localparam logic [1:0] CMD_WBEGIN = 2'd1;
    localparam logic [1:0] CMD_WEND = 2'd2;
    localparam logic [1:0] CMD_POST = 2'd3;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_FAILED = 3'd1;
    localparam logic [2:0] ST_INVALID = 3'd2;
    localparam logic [2:0] ST_STALE = 3'd3;
    localparam logic [2:0] ST_TIMEOUT = 3'd4;

    localparam int FL_SCHED = 0;
    localparam int FL_ABAND = 1;
    localparam int FL_WAIT = 2;
    localparam int FL_DONE = 3;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture input item
        logic clear;      // table clearing pass after reset
        logic fetch;      // read the entry of the named tag
        logic scan_init;  // start allocate scan
        logic scan_step;  // issue/examine one tag
        logic exec;       // apply command and register the result
    } ctrl_t;

    // datapath -> controller
    typedef struct packed {
        logic is_alloc;
        logic scan_done;
        logic clr_done;
    } stat_t;
endpackage
`default_nettype wire

[rtl/ttt_ctrl.sv]
// ----------------------------------------------------------------------------
// ttt_ctrl
// Sequencer: table clear, load, optional scan, execute, deliver.
// ----------------------------------------------------------------------------
`default_nettype none
module ttt_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  wire logic            out_ready,
    input  wire ttt_pkg::stat_t  stat,
    output ttt_pkg::ctrl_t       ctrl
);
    typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_DEC, S_SCAN, S_EXEC, S_OUT} state_t;
    state_t state_reg;

    always_comb
    begin
        ctrl = '0;
        in_ready = (state_reg == S_IDLE);
        ctrl.load = in_valid && in_ready;
        ctrl.clear = (state_reg == S_CLEAR);
        ctrl.fetch = (state_reg == S_DEC);
        ctrl.scan_init = (state_reg == S_DEC) && stat.is_alloc;
        ctrl.scan_step = (state_reg == S_SCAN);
        ctrl.exec = (state_reg == S_EXEC);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            out_valid <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_CLEAR: if (stat.clr_done) state_reg <= S_IDLE;
                S_IDLE: if (in_valid) state_reg <= S_DEC;
                S_DEC: state_reg <= stat.is_alloc ? S_SCAN : S_EXEC;
                S_SCAN: if (stat.scan_done) state_reg <= S_EXEC;
                S_EXEC:
                begin
                    state_reg <= S_OUT;
                    out_valid <= 1'b1;
                end
                S_OUT:
                    if (out_ready)
                    begin
                        out_valid <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

[rtl/ttt_datapath.sv]
// ----------------------------------------------------------------------------
// ttt_datapath
// Tag table, round-robin scan with oldest-stamp tracking, command execute.
// ----------------------------------------------------------------------------
`default_nettype none
module ttt_datapath #(
    parameter int NUM_TAGS = 256
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire ttt_pkg::ctrl_t ctrl,
    output ttt_pkg::stat_t      stat,
    input  wire logic [1:0]     command,
    input  wire logic [7:0]     conn_id,
    input  wire logic [7:0]     tag_id,
    input  wire logic           abandon,
    input  wire logic           allow_recycle,
    input  wire logic [7:0]     ret_value,
    input  wire logic           timed_out,
    output logic [2:0]          status_code,
    output logic [7:0]          granted_tag,
    output logic [7:0]          result_value,
    output logic                wake_waiter,
    output logic                release_valid,
    output logic [7:0]          released_conn
);
    localparam int IW = (NUM_TAGS > 2) ? $clog2(NUM_TAGS) : 1;
    localparam int CW = $clog2(NUM_TAGS + 1);

    typedef struct packed {
        logic [3:0]  flags;
        logic [8:0]  owner;
        logic [31:0] stamp;
        logic [7:0]  resp;
    } entry_t;

    // one table entry per tag; single registered read, single write per cycle
    entry_t tag_mem [NUM_TAGS];
    entry_t rd_data_reg;
    entry_t upd;
    entry_t wr_data;
    logic wr_en;
    logic [IW-1:0] wr_addr;

    logic [1:0] cmd_reg;
    logic [7:0] conn_reg, tag_reg, rv_reg;
    logic aband_reg, recyc_reg, tmo_reg;
    logic [7:0] last_reg;
    logic [31:0] seq_reg;

    logic [IW-1:0] clr_idx_reg;
    logic clr_done_reg;

    logic [IW-1:0] scan_addr_reg, chk_idx_reg;
    logic chk_vld_reg;
    logic [CW-1:0] iss_cnt_reg, eval_cnt_reg;
    logic found_reg, have_old_reg, pick_ok_reg;
    logic [IW-1:0] pick_reg;
    logic [31:0] old_stamp_reg;
    logic scan_issue, scan_eval;

    logic [2:0] res_status;
    logic [7:0] res_tag, res_value, res_conn;
    logic res_wake, res_rel;

    logic tag_range;
    logic [IW-1:0] tidx;
    logic [IW-1:0] start_idx;

    assign tag_range = ({24'd0, tag_reg} < 32'(NUM_TAGS));
    assign tidx = tag_reg[IW-1:0];
    assign stat.is_alloc = (cmd_reg == ttt_pkg::CMD_ALLOC);
    assign stat.scan_done = found_reg || (eval_cnt_reg == CW'(NUM_TAGS));
    assign stat.clr_done = clr_done_reg;
    assign scan_issue = ctrl.scan_step && (iss_cnt_reg != CW'(NUM_TAGS));
    assign scan_eval = ctrl.scan_step && chk_vld_reg && !found_reg;

    always_comb
    begin
        if ({24'd0, last_reg} + 32'd1 >= 32'(NUM_TAGS))
            start_idx = '0;
        else
            start_idx = IW'({24'd0, last_reg} + 32'd1);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            cmd_reg <= command;
            conn_reg <= conn_id;
            tag_reg <= tag_id;
            aband_reg <= abandon;
            recyc_reg <= allow_recycle;
            rv_reg <= ret_value;
            tmo_reg <= timed_out;
        end
    end

    always_ff @(posedge clk)
    begin
        if (scan_issue)
            rd_data_reg <= tag_mem[scan_addr_reg];
        else if (ctrl.fetch && tag_range)
            rd_data_reg <= tag_mem[tidx];
        if (wr_en)
            tag_mem[wr_addr] <= wr_data;
    end

    // clearing pass: one entry per cycle after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_idx_reg <= '0;
            clr_done_reg <= 1'b0;
        end
        else if (ctrl.clear && !clr_done_reg)
        begin
            if (32'(clr_idx_reg) == NUM_TAGS - 1)
                clr_done_reg <= 1'b1;
            else
                clr_idx_reg <= clr_idx_reg + IW'(1);
        end
    end

    // scan: each read is issued, then examined in the cycle after; tag 0 skipped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_addr_reg <= '0;
            chk_idx_reg <= '0;
            chk_vld_reg <= 1'b0;
            iss_cnt_reg <= '0;
            eval_cnt_reg <= '0;
            found_reg <= 1'b0;
            have_old_reg <= 1'b0;
            pick_reg <= '0;
            old_stamp_reg <= '0;
            pick_ok_reg <= 1'b0;
        end
        else if (ctrl.scan_init)
        begin
            scan_addr_reg <= start_idx;
            chk_vld_reg <= 1'b0;
            iss_cnt_reg <= '0;
            eval_cnt_reg <= '0;
            found_reg <= 1'b0;
            have_old_reg <= 1'b0;
            pick_ok_reg <= 1'b0;
        end
        else
        begin
            chk_vld_reg <= scan_issue;
            if (scan_issue)
            begin
                chk_idx_reg <= scan_addr_reg;
                iss_cnt_reg <= iss_cnt_reg + CW'(1);
                scan_addr_reg <= (32'(scan_addr_reg) == NUM_TAGS - 1) ? '0
                    : scan_addr_reg + IW'(1);
            end
            if (scan_eval)
            begin
                eval_cnt_reg <= eval_cnt_reg + CW'(1);
                if (chk_idx_reg != '0)
                begin
                    if (!have_old_reg || rd_data_reg.stamp < old_stamp_reg)
                    begin
                        old_stamp_reg <= rd_data_reg.stamp;
                        have_old_reg <= 1'b1;
                        if (rd_data_reg.flags != 4'd0 && recyc_reg)
                        begin
                            pick_reg <= chk_idx_reg;
                            pick_ok_reg <= 1'b1;
                        end
                    end
                    if (rd_data_reg.flags == 4'd0)
                    begin
                        found_reg <= 1'b1;
                        pick_reg <= chk_idx_reg;
                        pick_ok_reg <= 1'b1;
                    end
                end
            end
        end
    end

    // command execute on the fetched entry
    always_comb
    begin
        upd = rd_data_reg;
        res_status = ttt_pkg::ST_OK;
        res_tag = tag_reg;
        res_value = '0;
        res_wake = 1'b0;
        res_rel = 1'b0;
        res_conn = '0;
        case (cmd_reg)
            ttt_pkg::CMD_ALLOC:
                if (!pick_ok_reg)
                begin
                    res_status = ttt_pkg::ST_FAILED;
                    res_tag = '0;
                end
                else
                    res_tag = 8'(pick_reg);
            ttt_pkg::CMD_WBEGIN:
                if (!tag_range)
                    res_status = ttt_pkg::ST_INVALID;
                else if (rd_data_reg.flags == 4'd0 || rd_data_reg.owner != {1'b1, conn_reg})
                    res_status = ttt_pkg::ST_STALE;
                else
                    upd.flags[ttt_pkg::FL_WAIT] = 1'b1;
            ttt_pkg::CMD_WEND:
                if (!tag_range)
                    res_status = ttt_pkg::ST_INVALID;
                else
                begin
                    upd.owner = '0;
                    if (rd_data_reg.flags[ttt_pkg::FL_DONE] && !tmo_reg)
                    begin
                        res_value = rd_data_reg.resp;
                        upd.flags = '0;
                    end
                    else
                    begin
                        upd.flags[ttt_pkg::FL_WAIT] = 1'b0;
                        if (tmo_reg)
                            res_status = ttt_pkg::ST_TIMEOUT;
                    end
                end
            ttt_pkg::CMD_POST:
                if (tag_reg == 8'd0)
                    res_status = ttt_pkg::ST_OK;
                else if (!tag_range)
                    res_status = ttt_pkg::ST_INVALID;
                else if (rd_data_reg.flags == 4'd0)
                    res_status = ttt_pkg::ST_INVALID;
                else if (rd_data_reg.owner[8] && rd_data_reg.flags[ttt_pkg::FL_WAIT])
                begin
                    upd.flags[ttt_pkg::FL_DONE] = 1'b1;
                    upd.resp = rv_reg;
                    res_wake = 1'b1;
                end
                else
                begin
                    if (!rd_data_reg.flags[ttt_pkg::FL_ABAND])
                        res_status = ttt_pkg::ST_TIMEOUT;
                    if (rd_data_reg.owner[8])
                    begin
                        res_rel = 1'b1;
                        res_conn = rd_data_reg.owner[7:0];
                        upd.owner = '0;
                    end
                    upd.flags = '0;
                end
            default: res_status = ttt_pkg::ST_OK;
        endcase
    end

    always_comb
    begin
        wr_en = 1'b0;
        wr_addr = tidx;
        wr_data = upd;
        if (ctrl.clear && !clr_done_reg)
        begin
            wr_en = 1'b1;
            wr_addr = clr_idx_reg;
            wr_data = '0;
        end
        else if (ctrl.exec && stat.is_alloc)
        begin
            wr_en = pick_ok_reg;
            wr_addr = pick_reg;
            wr_data.flags = aband_reg ? 4'b0011 : 4'b0001;
            wr_data.owner = aband_reg ? 9'd0 : {1'b1, conn_reg};
            wr_data.stamp = seq_reg + 32'd1;
            wr_data.resp = '0;
        end
        else if (ctrl.exec && tag_range)
            wr_en = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg <= '0;
            seq_reg <= '0;
            status_code <= ttt_pkg::ST_OK;
            granted_tag <= '0;
            result_value <= '0;
            wake_waiter <= 1'b0;
            release_valid <= 1'b0;
            released_conn <= '0;
        end
        else if (ctrl.exec)
        begin
            status_code <= res_status;
            granted_tag <= res_tag;
            result_value <= res_value;
            wake_waiter <= res_wake;
            release_valid <= res_rel;
            released_conn <= res_conn;
            if (stat.is_alloc && pick_ok_reg)
            begin
                last_reg <= 8'(pick_reg);
                seq_reg <= seq_reg + 32'd1;
            end
        end
    end
endmodule
`default_nettype wire

[rtl/transaction_tag_tracker.sv]
// Flow: an item is captured, its tag entry fetched by a registered table read, the command
// executed and the result registered with out_valid, which holds until out_ready. Allocate adds
// a scan of one tag per cycle, ending at the first free nonzero tag or after all NUM_TAGS tags.
// Items are handled one at a time: in_ready is high only while idle.
// Reset: asynchronous; then a pass clears the tag table, with in_ready low.
// ----------------------------------------------------------------------------
// transaction_tag_tracker
// Request tag allocator with wait/post tracking.
// ----------------------------------------------------------------------------
`default_nettype none
`include "transaction_tag_tracker_assert.svh"
module transaction_tag_tracker #(
    parameter int NUM_TAGS = 256
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [1:0] command,
    input  wire logic [7:0] conn_id,
    input  wire logic [7:0] tag_id,
    input  wire logic       abandon,
    input  wire logic       allow_recycle,
    input  wire logic [7:0] ret_value,
    input  wire logic       timed_out,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [2:0]      status_code,
    output logic [7:0]      granted_tag,
    output logic [7:0]      result_value,
    output logic            wake_waiter,
    output logic            release_valid,
    output logic [7:0]      released_conn
);
    ttt_pkg::ctrl_t ctrl;
    ttt_pkg::stat_t stat;
    logic out_failed;

    assign out_failed = out_valid && status_code == ttt_pkg::ST_FAILED;

    ttt_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .out_valid(out_valid), .out_ready(out_ready), .stat(stat), .ctrl(ctrl)
    );

    ttt_datapath #(.NUM_TAGS(NUM_TAGS)) u_dp (
        .clk(clk), .rst_n(rst_n), .ctrl(ctrl), .stat(stat),
        .command(command), .conn_id(conn_id), .tag_id(tag_id), .abandon(abandon),
        .allow_recycle(allow_recycle), .ret_value(ret_value), .timed_out(timed_out),
        .status_code(status_code), .granted_tag(granted_tag),
        .result_value(result_value), .wake_waiter(wake_waiter),
        .release_valid(release_valid), .released_conn(released_conn)
    );

    `TTT_ASSERT_ALWAYS(a_no_overlap, !(in_ready && out_valid))
    `TTT_ASSERT_IMPL(a_fail_zero, out_failed, granted_tag == 8'd0)
    `TTT_ASSERT_IMPL(a_wake_ok, out_valid && wake_waiter, status_code == ttt_pkg::ST_OK && !release_valid)
endmodule
`default_nettype wire
